>>> rtl/msstb_pkg.sv
`default_nettype none

package msstb_pkg;

    localparam int SLOT_W     = 4;
    localparam int PERIOD_W   = 32;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int SIU_W      = 5;
    localparam int MASK_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    localparam logic [KIND_W-1:0] KIND_OK       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

    localparam logic REG_SLOTS_IN_USE     = 1'b0;
    localparam logic REG_SINGLE_SHOT_MASK = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [SLOT_W-1:0]   slot;
        logic [PERIOD_W-1:0] period_ticks;
    } t_cmd_item;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] result_slot;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [PERIOD_W-1:0] count;
    } t_slot_entry;

    typedef struct packed {
        logic [SIU_W-1:0]  slots_in_use;
        logic [MASK_W-1:0] single_shot_mask;
    } t_cfg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic accept;
        logic walk_clear;
        logic walk_step;
        logic flush;
    } t_dp_ctrl;

    typedef struct packed {
        logic walk_done;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/msstb_regs.sv
`default_nettype none

module msstb_regs (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [msstb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [msstb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [msstb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    output msstb_pkg::t_cfg                          o_cfg
);
    import msstb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[2])
                REG_SLOTS_IN_USE: begin
                    n_cfg.slots_in_use = pwdata[SIU_W-1:0];
                end
                REG_SINGLE_SHOT_MASK: begin
                    n_cfg.single_shot_mask = pwdata[MASK_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_SLOTS_IN_USE: begin
                prdata = CFG_DATA_W'(r_cfg.slots_in_use);
            end
            REG_SINGLE_SHOT_MASK: begin
                prdata = CFG_DATA_W'(r_cfg.single_shot_mask);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

>>> rtl/msstb_ctrl.sv
`default_nettype none

module msstb_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [msstb_pkg::CMD_W-1:0]   i_command,
    input  wire msstb_pkg::t_dp_stat           i_stat,
    output msstb_pkg::t_dp_ctrl                o_ctrl,
    output logic                               o_busy
);
    import msstb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        o_busy  = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_busy        = 1'b0;
                o_ctrl.accept = i_start;
                if (i_start && (i_command == CMD_TICK)) begin
                    o_ctrl.walk_clear = 1'b1;
                    n_state           = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.walk_done) begin
                    n_state = ST_FLUSH;
                end else begin
                    o_ctrl.walk_step = 1'b1;
                end
            end
            ST_FLUSH: begin
                o_ctrl.flush = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/msstb_datapath.sv
`default_nettype none

module msstb_datapath #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire msstb_pkg::t_cmd_item  i_item,
    input  wire msstb_pkg::t_cfg       i_cfg,
    input  wire msstb_pkg::t_dp_ctrl   i_ctrl,
    output msstb_pkg::t_dp_stat        o_stat,
    output logic                       o_strobe,
    output msstb_pkg::t_result         o_result
);
    import msstb_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PW = $clog2(NUM_SLOTS + 1);
    localparam int MW = (NUM_SLOTS > MASK_W) ? NUM_SLOTS : MASK_W;

    t_slot_entry mem [NUM_SLOTS];

    logic [PW-1:0]        active;
    logic                 start_ok;
    logic                 is_start;
    logic                 is_stop;
    logic [MW-1:0]        mask_ext;
    logic [NUM_SLOTS-1:0] ss_vec;

    logic [PW-1:0]        r_ptr;
    logic [PW-1:0]        n_ptr;
    logic                 r_proc_vld;
    logic [IW-1:0]        r_proc_idx;
    t_slot_entry          r_rdata;
    logic [NUM_SLOTS-1:0] r_running;
    logic [NUM_SLOTS-1:0] n_running;
    logic                 r_pend_vld;
    logic                 n_pend_vld;
    logic [IW-1:0]        r_pend_idx;
    logic [IW-1:0]        n_pend_idx;
    logic                 r_out_vld;
    logic                 n_out_vld;
    t_result              r_out;
    t_result              n_out;

    logic                 run;
    logic [PERIOD_W-1:0]  new_count;
    logic                 hit;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    t_slot_entry          wr_data;

    always_comb begin
        if (int'(i_cfg.slots_in_use) > NUM_SLOTS) begin
            active = PW'(NUM_SLOTS);
        end else begin
            active = PW'(i_cfg.slots_in_use);
        end
    end

    assign start_ok = int'(i_item.slot) < int'(active);
    assign is_start = i_ctrl.accept && (i_item.command == CMD_START);
    assign is_stop  = i_ctrl.accept && (i_item.command == CMD_STOP);
    assign mask_ext = MW'(i_cfg.single_shot_mask);

    always_comb begin
        for (int j = 0; j < NUM_SLOTS; j++) begin
            ss_vec[j] = (j < MASK_W) ? mask_ext[j] : 1'b0;
        end
    end

    assign o_stat.walk_done = (r_ptr >= active);

    assign run       = r_running[r_proc_idx];
    assign new_count = r_rdata.count + PERIOD_W'(1);
    assign hit       = r_proc_vld && run && (new_count == r_rdata.period);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_proc_idx;
        wr_data.period = r_rdata.period;
        wr_data.count  = hit ? '0 : new_count;
        if (r_proc_vld && run) begin
            wr_en = 1'b1;
        end else if (is_start && start_ok) begin
            wr_en          = 1'b1;
            wr_addr        = IW'(i_item.slot);
            wr_data.period = i_item.period_ticks;
            wr_data.count  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_ctrl.walk_step) begin
            r_rdata <= mem[r_ptr[IW-1:0]];
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_ctrl.walk_clear) begin
            n_ptr = '0;
        end else if (i_ctrl.walk_step) begin
            n_ptr = r_ptr + PW'(1);
        end
    end

    always_comb begin
        n_running = r_running;
        for (int j = 0; j < NUM_SLOTS; j++) begin
            if (is_start && start_ok && (int'(i_item.slot) == j)) begin
                n_running[j] = 1'b1;
            end
            if (is_stop && (int'(i_item.slot) == j)) begin
                n_running[j] = 1'b0;
            end
            if (hit && ss_vec[j] && (int'(r_proc_idx) == j)) begin
                n_running[j] = 1'b0;
            end
        end
    end

    always_comb begin
        n_out_vld  = 1'b0;
        n_out      = r_out;
        n_pend_vld = r_pend_vld;
        n_pend_idx = r_pend_idx;
        if (is_start) begin
            n_out_vld = 1'b1;
            n_out     = '{kind: start_ok ? KIND_OK : KIND_REJECTED,
                          result_slot: i_item.slot, last: 1'b1};
        end else if (is_stop) begin
            n_out_vld = 1'b1;
            n_out     = '{kind: KIND_OK, result_slot: i_item.slot, last: 1'b1};
        end else if (hit) begin
            if (r_pend_vld) begin
                n_out_vld = 1'b1;
                n_out     = '{kind: KIND_EXPIRED, result_slot: SLOT_W'(r_pend_idx),
                              last: 1'b0};
            end
            n_pend_vld = 1'b1;
            n_pend_idx = r_proc_idx;
        end else if (i_ctrl.flush && r_pend_vld) begin
            n_out_vld  = 1'b1;
            n_out      = '{kind: KIND_EXPIRED, result_slot: SLOT_W'(r_pend_idx),
                           last: 1'b1};
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr      <= '0;
            r_proc_vld <= 1'b0;
            r_running  <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_ptr      <= n_ptr;
            r_proc_vld <= i_ctrl.walk_step;
            r_running  <= n_running;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_proc_idx <= r_ptr[IW-1:0];
        r_pend_idx <= n_pend_idx;
        r_out      <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_result = r_out;

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.accept |-> (!r_proc_vld && !r_pend_vld))
        else $error("command accepted while a tick walk is still in flight");

    a_flush_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.flush |-> !r_proc_vld)
        else $error("flush overlaps processing of a slot");

    a_status_from_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.kind != KIND_EXPIRED)) |-> $past(i_ctrl.accept))
        else $error("status result without an accepted command");

endmodule

`default_nettype wire

>>> rtl/multi_slot_software_timer_bank_core.sv
`default_nettype none

// Bank of software timer slots driven by commands.
// A command transaction is accepted at a rising edge with start high and busy low;
// i_item carries the command (tick, start slot, stop slot), the slot and the period.
// Start and stop never raise busy: busy stays low and the single status
// transaction appears on o_result with o_strobe high in the following cycle.
// A tick walks the slots in use, min(slots_in_use, NUM_SLOTS) of them, one per
// cycle through the count/period memory; busy stays high during the walk, the
// registered memory read of the last slot and the final flush.
// Expiry transactions come out in slot order, at most one per cycle, while busy is
// high and in the first cycle after it falls; the last one of a tick has last set.
// A tick that expires nothing produces no transaction.
// Each result is shown for exactly one cycle and the receiver cannot stall it.
// The APB port writes slots_in_use at address 0 and single_shot_mask at 4,
// and should only be written while busy is low and no result is pending.
// Reset clears the registers, all running flags and the output strobe.
module multi_slot_software_timer_bank_core #(
    parameter int NUM_SLOTS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire msstb_pkg::t_cmd_item                i_item,
    output logic                                     o_strobe,
    output msstb_pkg::t_result                       o_result,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [msstb_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [msstb_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [msstb_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready
);
    import msstb_pkg::*;

    t_cfg     cfg;
    t_dp_ctrl dp_ctrl;
    t_dp_stat dp_stat;

    msstb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    msstb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_item.command),
        .i_stat    (dp_stat),
        .o_ctrl    (dp_ctrl),
        .o_busy    (busy)
    );

    msstb_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (cfg),
        .i_ctrl   (dp_ctrl),
        .o_stat   (dp_stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

`default_nettype wire
